[hdl/qrps_pkg.sv]
// ----------------------------------------------------------------------------
// qrps_pkg: shared constants for the queued relay pulse scheduler
// Field widths, register map and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package qrps_pkg;

  // Payload field widths
  localparam int TAG_W     = 16;
  localparam int TICKS_W   = 16;
  localparam int PENDING_W = 4;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DFLT = 8;
  localparam int TAG_BITS_DFLT    = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_PULSE_TICKS = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_t;

  localparam logic [TICKS_W-1:0] PULSE_TICKS_RST = 16'd500;
  localparam logic [TICKS_W-1:0] TICKS_SAT       = 16'hFFFF;

  // Request modes
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

endpackage

`default_nettype wire

[hdl/qrps_ram.sv]
// ----------------------------------------------------------------------------
// qrps_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered (read-before-write).
// ----------------------------------------------------------------------------
`default_nettype none

module qrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [WIDTH-1:0]    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/queued_relay_pulse_scheduler.sv]
// ----------------------------------------------------------------------------
// queued_relay_pulse_scheduler
// Queues command tags, runs one relay pulse at a time on tick requests and
// acknowledges finished pulses and dropped commands.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  request   req_valid/req_ready    mode, command_tag
//  result    rsp_valid/rsp_ready    relay_on, ack_valid, ack_tag, ack_error,
//                                   pending_count
//  config    APB psel/penable       pulse_ticks at byte address 0
//
//  One request per cycle while req_ready is high; each request yields one result
//  in the next cycle, set by the single result register after the next-state logic.
//  req_ready is high while the result register is empty or being drained,
//  so a stalled result blocks only the next request.
//  Synchronous reset clears queue pointers, pulse state and pulse_ticks = 500;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module queued_relay_pulse_scheduler #(
  parameter int QUEUE_DEPTH = qrps_pkg::QUEUE_DEPTH_DFLT,
  parameter int TAG_BITS    = qrps_pkg::TAG_BITS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            mode,
  input  logic [qrps_pkg::TAG_W-1:0]      command_tag,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            relay_on,
  output logic                            ack_valid,
  output logic [qrps_pkg::TAG_W-1:0]      ack_tag,
  output logic                            ack_error,
  output logic [qrps_pkg::PENDING_W-1:0]  pending_count,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qrps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [qrps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [qrps_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import qrps_pkg::*;

  localparam int StoreBits = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntBits:0] DepthW = (CntBits + 1)'(QUEUE_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [TICKS_W-1:0] pulse_ticks;
  reg_idx_t           reg_sel;

  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_TICKS_RST;
    end else if (psel && penable && pwrite && (reg_sel == REG_PULSE_TICKS)) begin
      pulse_ticks <= pwdata[TICKS_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PULSE_TICKS: prdata = {{(APB_DATA_W - TICKS_W){1'b0}}, pulse_ticks};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Scheduler state
  // --------------------------------------------------------------------------
  logic [PtrBits-1:0]   fifo_head,     fifo_head_next;
  logic [CntBits-1:0]   fifo_count,    fifo_count_next;
  logic                 pulse_active,  pulse_active_next;
  logic [TICKS_W-1:0]   elapsed_ticks, elapsed_ticks_next;
  logic [StoreBits-1:0] active_tag,    active_tag_next;

  logic                 accept;
  logic [StoreBits-1:0] req_tag;
  logic                 full;
  logic [CntBits:0]     wr_sum;
  logic [PtrBits-1:0]   wr_addr;
  logic                 wr_en;
  logic [PtrBits:0]     head_inc;
  logic [PtrBits-1:0]   head_wrap;
  logic [StoreBits-1:0] ram_rdata;
  logic                 byp_hit;
  logic [StoreBits-1:0] byp_tag;
  logic [StoreBits-1:0] head_tag;
  logic [TICKS_W-1:0]   elapsed_inc;
  logic                 ack_next;
  logic                 err_next;
  logic [StoreBits-1:0] ack_tag_next;
  logic [CntBits+PENDING_W-1:0] count_ext;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign req_tag   = command_tag[StoreBits-1:0];
  assign full      = ({1'b0, fifo_count} == DepthW);

  // Tail slot: head + count stays below twice the depth, one subtract wraps it
  always_comb begin
    wr_sum = (CntBits + 1)'(fifo_head) + {1'b0, fifo_count};
    if (wr_sum >= DepthW) begin
      wr_sum = wr_sum - DepthW;
    end
    wr_addr = wr_sum[PtrBits-1:0];
  end

  always_comb begin
    head_inc = {1'b0, fifo_head} + (PtrBits + 1)'(1);
    if (head_inc >= (PtrBits + 1)'(QUEUE_DEPTH)) begin
      head_wrap = '0;
    end else begin
      head_wrap = head_inc[PtrBits-1:0];
    end
  end

  assign wr_en    = accept && (mode == MODE_COMMAND) && !full;
  // RAM read data is registered; a write to the slot being read is forwarded
  assign head_tag = byp_hit ? byp_tag : ram_rdata;

  assign elapsed_inc = (elapsed_ticks < TICKS_SAT) ? elapsed_ticks + 16'd1 : elapsed_ticks;

  always_comb begin
    fifo_head_next     = fifo_head;
    fifo_count_next    = fifo_count;
    pulse_active_next  = pulse_active;
    elapsed_ticks_next = elapsed_ticks;
    active_tag_next    = active_tag;
    ack_next           = 1'b0;
    err_next           = 1'b0;
    ack_tag_next       = '0;

    if (accept) begin
      if (mode == MODE_COMMAND) begin
        if (full) begin
          // drop and answer with an error at once
          ack_next     = 1'b1;
          err_next     = 1'b1;
          ack_tag_next = req_tag;
        end else begin
          fifo_count_next = fifo_count + CntBits'(1);
        end
      end else begin
        if (pulse_active) begin
          elapsed_ticks_next = elapsed_inc;
          if (elapsed_inc >= pulse_ticks) begin
            pulse_active_next = 1'b0;
            ack_next          = 1'b1;
            ack_tag_next      = active_tag;
          end
        end
        // start the oldest waiting tag when idle after this tick
        if ((!pulse_active || (elapsed_inc >= pulse_ticks)) && (fifo_count != '0)) begin
          active_tag_next    = head_tag;
          fifo_head_next     = head_wrap;
          fifo_count_next    = fifo_count - CntBits'(1);
          elapsed_ticks_next = '0;
          pulse_active_next  = 1'b1;
        end
      end
    end
  end

  qrps_ram #(
    .WIDTH (StoreBits),
    .DEPTH (QUEUE_DEPTH)
  ) u_tag_fifo (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req_tag),
    .raddr (fifo_head_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head     <= '0;
      fifo_count    <= '0;
      pulse_active  <= 1'b0;
      elapsed_ticks <= '0;
      active_tag    <= '0;
      byp_hit       <= 1'b0;
    end else begin
      fifo_head     <= fifo_head_next;
      fifo_count    <= fifo_count_next;
      pulse_active  <= pulse_active_next;
      elapsed_ticks <= elapsed_ticks_next;
      active_tag    <= active_tag_next;
      byp_hit       <= wr_en && (wr_addr == fifo_head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_tag <= req_tag;
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign count_ext = {{PENDING_W{1'b0}}, fifo_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      relay_on      <= pulse_active_next;
      ack_valid     <= ack_next;
      ack_error     <= err_next;
      ack_tag       <= TAG_W'(ack_tag_next);
      pending_count <= count_ext[PENDING_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    {1'b0, fifo_count} <= DepthW)
    else $error("queue count above depth");

  a_err_has_ack : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ack_error |-> ack_valid)
    else $error("error flag without acknowledgement");

  a_enqueue : assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_COMMAND) && !full
      |=> fifo_count == $past(fifo_count) + CntBits'(1))
    else $error("accepted command not queued");

  a_cmd_holds_pulse : assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_COMMAND)
      |=> pulse_active == $past(pulse_active) && active_tag == $past(active_tag))
    else $error("pulse changed on a command request");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: queued_relay_pulse_scheduler
// Sends tick and command requests under random idling and result stalls. A
// scoreboard class predicts every result from its own copy of the queue and
// pulse state and checks each result as it drains. The pulse_ticks register
// is rewritten between phases through the APB port and read back.
// ----------------------------------------------------------------------------
module testbench;

  import qrps_pkg::*;

  localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DFLT;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int MAX_MSG_LINES = 30;

  localparam logic [APB_ADDR_W-1:0] ADDR_PULSE_TICKS = {REG_PULSE_TICKS, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED      = {REG_NONE, 2'b00};

  typedef struct packed {
    logic                 relay_on;
    logic                 ack_valid;
    logic [TAG_W-1:0]     ack_tag;
    logic                 ack_error;
    logic [PENDING_W-1:0] pending_count;
  } relay_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: pulse scheduler predictor and queue of expected results
  // --------------------------------------------------------------------------
  class relay_scoreboard;
    logic [TAG_W-1:0]   tag_store[QUEUE_DEPTH];
    int                 head;
    int                 waiting;
    bit                 pulsing;
    logic [TICKS_W-1:0] ticks_done;
    logic [TAG_W-1:0]   current_tag;
    logic [TICKS_W-1:0] pulse_len;
    relay_result_t      expected_q[$];
    int                 mismatches;

    function new();
      head        = 0;
      waiting     = 0;
      pulsing     = 1'b0;
      ticks_done  = '0;
      current_tag = '0;
      pulse_len   = PULSE_TICKS_RST;
      mismatches  = 0;
    endfunction

    function void flag_mismatch(string msg);
      if (mismatches < MAX_MSG_LINES)
        $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function bit quiet();
      return !pulsing && waiting == 0;
    endfunction

    // Pop the oldest tag into a fresh pulse when idle.
    function void launch_next();
      if (pulsing || waiting == 0)
        return;
      current_tag = tag_store[head];
      head        = (head + 1) % QUEUE_DEPTH;
      waiting--;
      ticks_done  = '0;
      pulsing     = 1'b1;
    endfunction

    function void note_request(logic req_mode, logic [TAG_W-1:0] tag);
      relay_result_t r;
      r = '0;
      if (req_mode == MODE_COMMAND) begin
        if (waiting >= QUEUE_DEPTH) begin
          r.ack_valid = 1'b1;
          r.ack_error = 1'b1;
          r.ack_tag   = tag;
        end else begin
          tag_store[(head + waiting) % QUEUE_DEPTH] = tag;
          waiting++;
        end
      end else if (!pulsing) begin
        launch_next();
      end else begin
        if (ticks_done != TICKS_SAT)
          ticks_done++;
        if (ticks_done >= pulse_len) begin
          pulsing     = 1'b0;
          r.ack_valid = 1'b1;
          r.ack_tag   = current_tag;
          launch_next();
        end
      end
      r.relay_on      = pulsing;
      r.pending_count = PENDING_W'(waiting);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, longint got, longint want);
      if (got != want)
        flag_mismatch($sformatf("%s: got 0x%0h expected 0x%0h", name, got, want));
    endfunction

    function void check_result(relay_result_t got);
      relay_result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("relay_on", got.relay_on, want.relay_on);
      compare_field("ack_valid", got.ack_valid, want.ack_valid);
      compare_field("ack_tag", got.ack_tag, want.ack_tag);
      compare_field("ack_error", got.ack_error, want.ack_error);
      compare_field("pending_count", got.pending_count, want.pending_count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic                  mode = MODE_TICK;
  logic [TAG_W-1:0]      command_tag = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic                  relay_on;
  logic                  ack_valid;
  logic [TAG_W-1:0]      ack_tag;
  logic                  ack_error;
  logic [PENDING_W-1:0]  pending_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  relay_scoreboard sb;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queued_relay_pulse_scheduler DUT (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .mode          (mode),
    .command_tag   (command_tag),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .relay_on      (relay_on),
    .ack_valid     (ack_valid),
    .ack_tag       (ack_tag),
    .ack_error     (ack_error),
    .pending_count (pending_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, check on every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= pick_gap();
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready && sb != null)
      sb.check_result(relay_result_t'({relay_on, ack_valid, ack_tag, ack_error,
                                        pending_count}));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_request(input logic req_mode, input logic [TAG_W-1:0] tag);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    mode        <= req_mode;
    command_tag <= tag;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req_mode, tag);
  endtask

  task automatic send_tick();
    send_request(MODE_TICK, TAG_W'($urandom));
  endtask

  function automatic logic [TAG_W-1:0] random_tag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return TAG_W'($urandom);
    endcase
  endfunction

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_pulse_len_readback();
    logic [APB_DATA_W-1:0] rd;
    apb_read(ADDR_PULSE_TICKS, rd);
    if (rd[TICKS_W-1:0] != sb.pulse_len)
      sb.flag_mismatch($sformatf("pulse_ticks readback: got %0d expected %0d",
                                 rd[TICKS_W-1:0], sb.pulse_len));
  endtask

  // Only touch the register once the block has answered everything.
  task automatic set_pulse_len(input logic [TICKS_W-1:0] value);
    wait_results_drained();
    apb_write(ADDR_PULSE_TICKS, {16'($urandom), value});
    sb.pulse_len = value;
    check_pulse_len_readback();
  endtask

  // Bursts with a varying command share so the queue both fills and empties.
  task automatic run_random(input int count);
    int left;
    int burst;
    int cmd_pct;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(15, 60);
      case ($urandom_range(0, 4))
        0:       cmd_pct = 0;
        1:       cmd_pct = 15;
        2:       cmd_pct = 35;
        3:       cmd_pct = 55;
        default: cmd_pct = 80;
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < cmd_pct)
          send_request(MODE_COMMAND, random_tag());
        else
          send_tick();
        left--;
      end
      if ($urandom_range(0, 5) == 0)
        wait_results_drained();
    end
  endtask

  // Tick until no pulse runs and the queue is empty.
  task automatic flush_queue();
    while (!sb.quiet()) send_tick();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_pulse_len_readback();

    // Directed part at the reset pulse length
    send_tick();
    send_request(MODE_COMMAND, 16'h0000);
    send_request(MODE_COMMAND, 16'hFFFF);
    send_request(MODE_COMMAND, 16'hA5A5);
    send_request(MODE_COMMAND, 16'h5A5A);
    repeat (4) send_request(MODE_COMMAND, random_tag());
    send_request(MODE_COMMAND, 16'h1234);
    send_tick();
    send_request(MODE_COMMAND, 16'h8001);
    send_request(MODE_COMMAND, 16'h7FFE);
    repeat (520) begin
      if ($urandom_range(0, 99) < 6)
        send_request(MODE_COMMAND, random_tag());
      else
        send_tick();
    end

    // Zero length behaves as one tick
    set_pulse_len(16'd0);
    repeat (6) send_tick();
    send_request(MODE_COMMAND, 16'hFFFF);
    send_request(MODE_COMMAND, 16'h0001);
    repeat (4) send_tick();
    run_random(50);

    // The unused address must leave pulse_ticks alone
    wait_results_drained();
    apb_write(ADDR_UNUSED, $urandom);
    check_pulse_len_readback();

    set_pulse_len(16'd1);
    run_random(50);
    set_pulse_len(16'd2);
    run_random(50);
    set_pulse_len(16'd3);
    run_random(50);
    set_pulse_len(TICKS_W'($urandom_range(4, 20)));
    run_random(50);

    // Longest pulse length, run without idling
    flush_queue();
    set_pulse_len(16'hFFFF);
    idle_on = 1'b0;
    send_request(MODE_COMMAND, random_tag());
    repeat (30) send_tick();
    wait_results_drained();
    idle_on = 1'b1;

    // Shrink the length under the running pulse: it ends on the next tick
    set_pulse_len(TICKS_W'($urandom_range(1, 6)));
    run_random(50);

    wait_results_drained();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
